// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/hcbd_pkg.sv
// Package for the HTTP chunked body decoder: item types, status codes, character codes.
// No dependencies.
package hcbd_pkg;

  // Width of the chunk size counter.
  localparam int unsigned SizeBits = 32;

  localparam logic [1:0] StBusy  = 2'd0;
  localparam logic [1:0] StDone  = 2'd1;
  localparam logic [1:0] StError = 2'd2;

  localparam logic [7:0] ChLf = 8'h0A;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic [1:0] status;
  } out_item_t;

endpackage

// File: rtl/hcbd_parser.sv
// Chunked-body parser state and per-byte decode logic.
// Depends on hcbd_pkg. The result is combinational; the state advances on step_i.
module hcbd_parser import hcbd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  typedef enum logic [2:0] {
    PhSize  = 3'd0,
    PhData  = 3'd1,
    PhDelim = 3'd2,
    PhDone  = 3'd3,
    PhError = 3'd4
  } phase_e;

  phase_e                phase_q, phase_d, phase_c;
  logic [SizeBits-1:0]   rem_q, rem_d, rem_c, rem_dec;
  logic                  past_hex_q, past_hex_d, past_hex_c;
  logic                  delim_seen_q, delim_seen_d, delim_seen_c;
  logic                  is_hex;
  logic [3:0]            hex_val;
  logic                  valid;
  logic [1:0]            status;

  // Decode one ASCII hex digit, either case.
  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (item_i.in_byte inside {[8'h30:8'h39]}) begin
      hex_val = item_i.in_byte[3:0];
    end else if (item_i.in_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      hex_val = item_i.in_byte[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    // restart acts before this byte
    phase_c      = item_i.restart ? PhSize : phase_q;
    rem_c        = item_i.restart ? '0 : rem_q;
    past_hex_c   = item_i.restart ? 1'b0 : past_hex_q;
    delim_seen_c = item_i.restart ? 1'b0 : delim_seen_q;

    phase_d      = phase_c;
    rem_d        = rem_c;
    past_hex_d   = past_hex_c;
    delim_seen_d = delim_seen_c;
    rem_dec      = rem_c - SizeBits'(1);
    valid        = 1'b0;
    status       = StBusy;

    case (phase_c)
      PhSize: begin
        if (item_i.in_byte == ChLf) begin
          past_hex_d = 1'b0;
          if (rem_c == '0) begin
            phase_d = PhDone;
            status  = StDone;
          end else begin
            phase_d = PhData;
          end
        end else if (!past_hex_c) begin
          if (!is_hex) begin
            past_hex_d = 1'b1;
          end else if (rem_c[SizeBits-1 -: 4] != 4'd0) begin
            // next digit would overflow the counter
            phase_d = PhError;
            status  = StError;
          end else begin
            rem_d = {rem_c[SizeBits-5:0], hex_val};
          end
        end
      end
      PhData: begin
        valid = 1'b1;
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          phase_d      = PhDelim;
          delim_seen_d = 1'b0;
        end
      end
      PhDelim: begin
        if (item_i.in_byte == ChLf) begin
          phase_d      = PhSize;
          rem_d        = '0;
          past_hex_d   = 1'b0;
          delim_seen_d = 1'b0;
        end else if (!delim_seen_c) begin
          delim_seen_d = 1'b1;
        end else begin
          phase_d = PhError;
          status  = StError;
        end
      end
      PhDone: begin
        status = StDone;
      end
      default: begin
        status = StError;
      end
    endcase

    result_o.payload_byte  = valid ? item_i.in_byte : 8'd0;
    result_o.payload_valid = valid;
    result_o.status        = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhSize;
      rem_q        <= '0;
      past_hex_q   <= 1'b0;
      delim_seen_q <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      rem_q        <= rem_d;
      past_hex_q   <= past_hex_d;
      delim_seen_q <= delim_seen_d;
    end
  end

endmodule

// File: rtl/http_chunked_body_decoder_top.sv
// Top level of the HTTP chunked body decoder: input register, parser, result register.
// Depends on hcbd_pkg, hcbd_parser and assert_macros.svh.
//
// Usage: feed the raw chunked body one byte per item on the input channel
// (in_valid_i / in_ready_o / in_item_i). Set restart in an item to begin a new
// body with that byte. Every input item yields exactly one result item on the
// output channel (out_valid_o / out_ready_i / out_item_o): payload_valid marks
// a data byte, status reports in progress, body done or format error.
// Path: an accepted item is held in the input register, its result is then loaded
// into the result register and offered there; a stall on the output keeps the item
// in the input register until the result register is free.
// Throughput: one item per cycle if not stalled; the per-byte decode (shift-in
// of a hex digit or a counter decrement) is one pass of logic between both registers.
// Stall: while the result register is held by the receiver, the input register
// keeps its item, or takes one if it was empty; after that the input channel
// takes no further item until the result register drains.
// Reset: both registers empty, parser at the start of a size line with a zero count.
`include "assert_macros.svh"
module http_chunked_body_decoder_top import hcbd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  in_item_t  in_item_q;
  logic      in_valid_q, in_valid_d;
  out_item_t out_item_q;
  out_item_t result;
  logic      out_valid_q, out_valid_d;
  logic      advance;

  // Move the held item through the parser when the result register is free.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  assign in_valid_d  = in_ready_o ? in_valid_i : in_valid_q;
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  hcbd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `ASSERT_IMPL(a_data_busy, clk_i, rst_ni, out_valid_o && out_item_o.payload_valid,
    out_item_o.status == StBusy)
  `ASSERT_IMPL(a_nondata_zero, clk_i, rst_ni, out_valid_o && !out_item_o.payload_valid,
    out_item_o.payload_byte == 8'd0)
  `ASSERT_NEXT(a_hold_input, clk_i, rst_ni, in_valid_q && !advance, in_valid_q)
  `ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, advance, out_valid_q)

endmodule

// File: tb/hcbd_checker.sv
// Result checker for the HTTP chunked body decoder: predicts each result from accepted input
// items and compares it with the output channel. Depends on hcbd_pkg.
`timescale 1ns / 1ps
module hcbd_checker import hcbd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o
);

  typedef enum logic [2:0] {
    PhSize  = 3'd0,
    PhData  = 3'd1,
    PhDelim = 3'd2,
    PhDone  = 3'd3,
    PhError = 3'd4
  } parse_phase_e;

  parse_phase_e        phase;
  logic [SizeBits-1:0] chunk_count;
  logic                past_digits;
  logic                delim_seen;
  out_item_t           expected_q[$];
  out_item_t           oldest;

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  // Advance the parser by one byte and return the result it gives.
  function automatic out_item_t decode_byte(in_item_t it);
    out_item_t r;
    int d;
    r = '0;
    r.status = StBusy;
    if (it.restart) begin
      phase       = PhSize;
      chunk_count = '0;
      past_digits = 1'b0;
      delim_seen  = 1'b0;
    end
    case (phase)
      PhSize: begin
        if (it.in_byte == ChLf) begin
          past_digits = 1'b0;
          if (chunk_count == '0) begin
            phase    = PhDone;
            r.status = StDone;
          end else begin
            phase = PhData;
          end
        end else if (!past_digits) begin
          d = hex_digit(it.in_byte);
          if (d < 0) begin
            past_digits = 1'b1;
          end else if (chunk_count[SizeBits-1 -: 4] != 4'd0) begin
            phase    = PhError;
            r.status = StError;
          end else begin
            chunk_count = {chunk_count[SizeBits-5:0], d[3:0]};
          end
        end
      end
      PhData: begin
        r.payload_valid = 1'b1;
        r.payload_byte  = it.in_byte;
        chunk_count     = chunk_count - SizeBits'(1);
        if (chunk_count == '0) begin
          phase      = PhDelim;
          delim_seen = 1'b0;
        end
      end
      PhDelim: begin
        if (it.in_byte == ChLf) begin
          phase       = PhSize;
          chunk_count = '0;
          past_digits = 1'b0;
          delim_seen  = 1'b0;
        end else if (!delim_seen) begin
          delim_seen = 1'b1;
        end else begin
          phase    = PhError;
          r.status = StError;
        end
      end
      PhDone: r.status = StDone;
      default: r.status = StError;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase        = PhSize;
      chunk_count  = '0;
      past_digits  = 1'b0;
      delim_seen   = 1'b0;
      expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h", $time, out_item_i);
          fail_count_o++;
        end else begin
          oldest = expected_q.pop_front();
          check_field("payload_byte", oldest.payload_byte, out_item_i.payload_byte);
          check_field("payload_valid", oldest.payload_valid, out_item_i.payload_valid);
          check_field("status", oldest.status, out_item_i.status);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(decode_byte(in_item_i));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// File: tb/tb_top.sv
// Testbench top for the HTTP chunked body decoder: clock, reset, byte stream stimulus and
// verdict. Depends on hcbd_pkg, http_chunked_body_decoder_top and hcbd_checker.
`timescale 1ns / 1ps
module tb_top;
  import hcbd_pkg::*;

  localparam logic [7:0] ChCr       = 8'h0D;
  localparam logic [7:0] ChSemi     = 8'h3B;
  localparam int         ItemTarget = 950;
  localparam int         CycleLimit = 200000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   items_sent = 0;
  logic steady = 1'b0;
  logic restart_due = 1'b0;

  http_chunked_body_decoder_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  hcbd_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 30);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(int v, bit upper);
    if (v < 10) return 8'("0" + v);
    return upper ? 8'("A" + v - 10) : 8'("a" + v - 10);
  endfunction

  function automatic logic [7:0] non_lf_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    return (b == ChLf) ? ChCr : b;
  endfunction

  // Offer one item and hold it until accepted; a pending body start forces restart.
  task automatic send_byte(logic [7:0] b, logic rs);
    in_valid        <= 1'b1;
    in_item.in_byte <= b;
    in_item.restart <= rs | restart_due;
    restart_due = 1'b0;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    steady = (items_sent >= 400) && (items_sent < 550);
    if (!steady && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // One chunked body with random sizes, extensions and delimiters; a few go bad on purpose.
  task automatic send_body();
    int sz;
    int pick;
    restart_due = 1'b1;
    if ($urandom_range(99) < 4) begin
      // nine digits with a nonzero lead overflow the size counter
      send_byte(hex_char($urandom_range(1, 15), $urandom_range(1)), 1'b0);
      repeat ($urandom_range(8, 10)) send_byte(hex_char($urandom_range(15), $urandom_range(1)), 1'b0);
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(255)), 1'b0);
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      sz = ($urandom_range(9) == 0) ? $urandom_range(16, 60) : $urandom_range(1, 6);
      repeat ($urandom_range(0, 2)) send_byte("0", 1'b0);
      if (sz > 15) send_byte(hex_char(sz >> 4, $urandom_range(1)), 1'b0);
      send_byte(hex_char(sz & 15, $urandom_range(1)), 1'b0);
      if ($urandom_range(3) == 0) begin
        send_byte(ChSemi, 1'b0);
        repeat ($urandom_range(0, 4)) send_byte(non_lf_byte(), 1'b0);
      end
      if ($urandom_range(4) != 0) send_byte(ChCr, 1'b0);
      send_byte(ChLf, 1'b0);
      repeat (sz) send_byte(8'($urandom_range(255)), 1'b0);
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_byte(ChCr, 1'b0);
        send_byte(ChLf, 1'b0);
      end else if (pick < 82) begin
        send_byte(ChLf, 1'b0);
      end else if (pick < 94) begin
        send_byte(non_lf_byte(), 1'b0);
        send_byte(ChLf, 1'b0);
      end else begin
        // two bytes before LF break the delimiter line
        send_byte(non_lf_byte(), 1'b0);
        send_byte(non_lf_byte(), 1'b0);
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(255)), 1'b0);
        return;
      end
    end
    repeat ($urandom_range(0, 3)) send_byte("0", 1'b0);
    if ($urandom_range(4) != 0) send_byte(ChCr, 1'b0);
    send_byte(ChLf, 1'b0);
    repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty size line ends the body at once; done then sticks
    send_byte(ChLf, 1'b1);
    send_byte(8'hFF, 1'b0);
    // mixed-case hex digits, then one digit too many
    for (int i = 0; i < 8; i++) send_byte(i[0] ? "f" : "F", i == 0);
    send_byte("a", 1'b0);
    send_byte(8'h00, 1'b0);
    // two-byte chunk with an extension, then a long delimiter
    send_byte("2", 1'b1);
    send_byte(ChSemi, 1'b0);
    send_byte(ChCr, 1'b0);
    send_byte(ChLf, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte("x", 1'b0);
    send_byte("y", 1'b0);
    // LF as payload, bare LF delimiter, empty last size line
    send_byte("1", 1'b1);
    send_byte(ChLf, 1'b0);
    send_byte(ChLf, 1'b0);
    send_byte(ChLf, 1'b0);
    send_byte(ChLf, 1'b0);

    while (items_sent < ItemTarget) begin
      if ($urandom_range(99) < 85) begin
        send_body();
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
        end
      end
    end
    // drop valid at the edge that took the last item
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
